// File: rtl/tgadec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgadec_pkg
// shared types and constants of the tga pixel data decoder
// ----------------------------------------------------------------------------
package tgadec_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_ALPHA_PRESENT    = 3'd2,
        REG_RUN_LENGTH_CODED = 3'd3,
        REG_BOTTOM_UP        = 3'd4
    } t_cfg_reg;

    localparam int RST_IMAGE_WIDTH  = 64;
    localparam int RST_IMAGE_HEIGHT = 64;

    // stream payload
    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int ROW_OUT_W   = 12;
    localparam int COL_OUT_W   = 12;
    localparam int LEN_W       = 8;

    // packet byte layout
    localparam int                PKT_RUN_BIT    = 7;
    localparam logic [6:0]        PKT_COUNT_MASK = 7'h7f;
    localparam logic [BYTE_W-1:0] OPAQUE         = 8'hff;

    // byte position that completes a pixel
    localparam logic [1:0] LAST_BYTE_ALPHA = 2'd3;
    localparam logic [1:0] LAST_BYTE_RGB   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take_pkt;
        logic take_pix;
        logic final_pix;
        logic do_wrap;
        logic do_finish;
        logic do_span;
    } t_cmd;

    typedef struct packed {
        logic finished;
        logic expect_pkt;
        logic byte_final;
        logic count_zero;
        logic rows_full;
        logic col_over;
        logic out_free;
        logic span_last;
    } t_status;

endpackage
`default_nettype wire

// File: rtl/tgadec_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgadec_cfg
// configuration registers, width and height stored already saturated
// ----------------------------------------------------------------------------
module tgadec_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW = $clog2(MAX_WIDTH + 1),
    parameter int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [tgadec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [tgadec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [CW-1:0]                       o_width,
    output logic [RW-1:0]                       o_height,
    output logic [RW-1:0]                       o_height_m1,
    output logic                                o_alpha,
    output logic                                o_rle,
    output logic                                o_bottom_up
);
    import tgadec_pkg::*;

    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

    logic [31:0]   cfg_ext;
    logic [CW-1:0] n_width;
    logic [RW-1:0] n_height;

    logic [CW-1:0] r_width;
    logic [RW-1:0] r_height;
    logic [RW-1:0] r_height_m1;
    logic          r_alpha;
    logic          r_rle;
    logic          r_bottom_up;

    assign cfg_ext = 32'(i_cfg_data);

    // saturate to 3..MAX_WIDTH and 1..MAX_HEIGHT
    always_comb begin
        if (cfg_ext < 32'd3) begin
            n_width = CW'(3);
        end else if (cfg_ext > 32'(MAX_WIDTH)) begin
            n_width = CW'(MAX_WIDTH);
        end else begin
            n_width = CW'(cfg_ext);
        end
        if (cfg_ext < 32'd1) begin
            n_height = RW'(1);
        end else if (cfg_ext > 32'(MAX_HEIGHT)) begin
            n_height = RW'(MAX_HEIGHT);
        end else begin
            n_height = RW'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CW'(RST_W);
            r_height    <= RW'(RST_H);
            r_height_m1 <= RW'(RST_H - 1);
            r_alpha     <= 1'b0;
            r_rle       <= 1'b1;
            r_bottom_up <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    r_width <= n_width;
                end
                REG_IMAGE_HEIGHT: begin
                    r_height    <= n_height;
                    r_height_m1 <= n_height - RW'(1);
                end
                REG_ALPHA_PRESENT: begin
                    r_alpha <= i_cfg_data[0];
                end
                REG_RUN_LENGTH_CODED: begin
                    r_rle <= i_cfg_data[0];
                end
                REG_BOTTOM_UP: begin
                    r_bottom_up <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_width     = r_width;
    assign o_height    = r_height;
    assign o_height_m1 = r_height_m1;
    assign o_alpha     = r_alpha;
    assign o_rle       = r_rle;
    assign o_bottom_up = r_bottom_up;

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_width) >= 32'd3) && (32'(r_width) <= 32'(MAX_WIDTH)))
        else $error("effective width out of range");
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_height != '0) && (32'(r_height) <= 32'(MAX_HEIGHT)))
        else $error("effective height out of range");
    a_height_m1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_height_m1 == r_height - RW'(1))
        else $error("height minus one out of step with height");

endmodule
`default_nettype wire

// File: rtl/tgadec_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgadec_ctrl
// sequencer: takes bytes while idle, walks the spans of a finished pixel
// ----------------------------------------------------------------------------
module tgadec_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  tgadec_pkg::t_status    i_status,
    output tgadec_pkg::t_cmd       o_cmd
);
    import tgadec_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && !i_status.finished) begin
                    if (i_status.expect_pkt) begin
                        o_cmd.take_pkt = 1'b1;
                    end else if (!i_status.byte_final) begin
                        o_cmd.take_pix = 1'b1;
                    end else begin
                        o_cmd.final_pix = 1'b1;
                        n_state         = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.count_zero || i_status.finished) begin
                    n_state = ST_IDLE;
                end else if (i_status.rows_full) begin
                    o_cmd.do_finish = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_status.col_over) begin
                    o_cmd.do_wrap = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.do_span = 1'b1;
                    if (i_status.span_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");
    a_byte_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_pkt || o_cmd.take_pix || o_cmd.final_pix)
        |-> (r_state == ST_IDLE) && i_valid)
        else $error("byte consumed outside idle");
    a_final_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.final_pix |=> (r_state == ST_EMIT) && !o_ready)
        else $error("pixel completion did not start span emission");

endmodule
`default_nettype wire

// File: rtl/tgadec_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgadec_dp
// pixel assembly, packet state, position counters and span output register
// ----------------------------------------------------------------------------
module tgadec_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW = $clog2(MAX_WIDTH + 1),
    parameter int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  tgadec_pkg::t_cmd                     i_cmd,
    output tgadec_pkg::t_status                  o_status,
    input  wire  [tgadec_pkg::BYTE_W-1:0]        i_byte,
    input  wire  [CW-1:0]                        i_width,
    input  wire  [RW-1:0]                        i_height,
    input  wire  [RW-1:0]                        i_height_m1,
    input  wire                                  i_alpha,
    input  wire                                  i_rle,
    input  wire                                  i_bottom_up,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [tgadec_pkg::OUT_TDATA_W-1:0]   o_out_data,
    output logic                                 o_out_last
);
    import tgadec_pkg::*;

    localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    // control state
    logic          r_expect;
    logic          r_is_run;
    logic [7:0]    r_pix_left;
    logic [1:0]    r_bip;
    logic [LEN_W-1:0] r_count;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_rows;
    logic          r_finished;
    logic          r_out_valid;

    // payload
    logic [23:0]       r_hold;
    logic [BYTE_W-1:0] r_alpha_byte;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic [1:0]    last_pos;
    logic [SW-1:0] rem;
    logic [SW-1:0] cnt;
    logic [SW-1:0] take;
    logic          row_fits;
    logic          row_last;
    logic [RW-1:0] out_row;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic          n_out_last;

    assign last_pos = i_alpha ? LAST_BYTE_ALPHA : LAST_BYTE_RGB;

    // span length is the smaller of what is left in the row and in the run
    assign rem      = SW'(i_width) - SW'(r_col);
    assign cnt      = SW'(r_count);
    assign row_fits = (rem <= cnt);
    assign take     = row_fits ? rem : cnt;
    assign row_last = (r_rows == i_height_m1);

    assign out_row  = i_bottom_up ? (i_height_m1 - r_rows) : r_rows;
    assign row_ext  = 32'(out_row);
    assign col_ext  = 32'(r_col);

    assign n_out_data = {r_alpha_byte, r_hold[23:16], r_hold[15:8], r_hold[7:0],
                         take[LEN_W-1:0], col_ext[COL_OUT_W-1:0], row_ext[ROW_OUT_W-1:0]};
    assign n_out_last = row_fits && row_last;

    always_comb begin
        o_status            = '0;
        o_status.finished   = r_finished;
        o_status.expect_pkt = i_rle && r_expect;
        o_status.byte_final = (r_bip >= last_pos);
        o_status.count_zero = (r_count == '0);
        o_status.rows_full  = (r_rows >= i_height);
        o_status.col_over   = (r_col >= i_width);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.span_last  = (cnt <= rem) || (row_fits && row_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect   <= 1'b1;
            r_is_run   <= 1'b0;
            r_pix_left <= '0;
            r_bip      <= '0;
            r_count    <= '0;
            r_col      <= '0;
            r_rows     <= '0;
            r_finished <= 1'b0;
        end else begin
            if (i_cmd.take_pkt) begin
                r_is_run   <= i_byte[PKT_RUN_BIT];
                r_pix_left <= {1'b0, i_byte[6:0] & PKT_COUNT_MASK} + 8'd1;
                r_expect   <= 1'b0;
                r_bip      <= '0;
            end
            if (i_cmd.take_pix) begin
                r_bip <= r_bip + 2'd1;
            end
            if (i_cmd.final_pix) begin
                r_bip <= '0;
                if (!i_rle) begin
                    r_count <= LEN_W'(1);
                end else if (r_is_run) begin
                    r_count    <= r_pix_left;
                    r_pix_left <= '0;
                    r_expect   <= 1'b1;
                end else if (r_pix_left != '0) begin
                    r_count    <= LEN_W'(1);
                    r_pix_left <= r_pix_left - 8'd1;
                    if (r_pix_left == 8'd1) begin
                        r_expect <= 1'b1;
                    end
                end else begin
                    // raw packet already used up: pixel dropped
                    r_count  <= '0;
                    r_expect <= 1'b1;
                end
            end
            if (i_cmd.do_wrap) begin
                r_col  <= '0;
                r_rows <= r_rows + RW'(1);
            end
            if (i_cmd.do_finish) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.do_span) begin
                r_count <= r_count - take[LEN_W-1:0];
                if (row_fits) begin
                    r_col  <= '0;
                    r_rows <= r_rows + RW'(1);
                    if (row_last) begin
                        r_finished <= 1'b1;
                    end
                end else begin
                    r_col <= r_col + take[CW-1:0];
                end
            end
        end
    end

    // pixel bytes land in blue, green, red order; alpha is kept apart
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pix || i_cmd.final_pix) begin
            case (r_bip)
                2'd0:    r_hold[7:0]   <= i_byte;
                2'd1:    r_hold[15:8]  <= i_byte;
                2'd2:    r_hold[23:16] <= i_byte;
                default: begin
                end
            endcase
        end
        if (i_cmd.final_pix) begin
            r_alpha_byte <= i_alpha ? i_byte : OPAQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_span) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_span) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag cleared without reset");
    a_span_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_span |-> (r_col < i_width) && (r_count != '0) && (r_rows < i_height))
        else $error("span issued outside the image or with empty run");
    a_last_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_span && n_out_last) |=> r_finished && r_out_valid && o_out_last)
        else $error("closing span did not finish the image");
    a_pixel_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.final_pix |=> (r_bip == '0))
        else $error("byte position not cleared after pixel");

endmodule
`default_nettype wire

// File: rtl/tga_rle_pixel_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// tga pixel data decoder for 24 and 32 bpp images, raw or run-length coded
// ----------------------------------------------------------------------------
// usage
//   s_axis carries the pixel data bytes that follow the header, one byte
//   per request. the header is loaded beforehand through the write port
//   (index 0 width, 1 height, 2 alpha present, 3 run-length coded,
//   4 bottom up); write it only while the decoder is idle.
//   m_axis carries one span per request: memory row, start column, length
//   and colour, with tlast marking the span that fills the last pixel.
// timing
//   packet bytes and pixel bytes other than the last of a pixel are taken
//   while the sequencer is idle. the last byte of a pixel starts the span
//   sequencer, which issues one span per cycle while the output register
//   is free (one span per row touched), or goes back to idle with no span
//   when the pixel gives none; s_axis_tready is low meanwhile. a span
//   shows on m_axis the cycle after it is issued.
// reset
//   header registers return to 64 x 64, no alpha, run-length coded,
//   bottom up; the decoder waits for a packet byte at the first image row.
// stalls
//   a held-up span sits in the output register; further bytes are still
//   taken, and the sequencer waits only when it has a new span to place.
//   after the image is full every byte is taken and dropped.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration writes
    input  wire                                  i_cfg_we,
    input  wire  [tgadec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [tgadec_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // byte stream in
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [tgadec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    // span stream out
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [11:0] row, [23:12] col_start, [31:24] span_length, [39:32] blue,
    // [47:40] green, [55:48] red, [63:56] alpha
    output logic [tgadec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast    // image_done
);
    import tgadec_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // effective header values
    logic [CW-1:0] width;
    logic [RW-1:0] height;
    logic [RW-1:0] height_m1;
    logic          alpha_present;
    logic          rle;
    logic          bottom_up;

    // controller to datapath
    t_cmd    cmd;
    t_status status;

    // header registers, saturated on write
    tgadec_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_width     (width),
        .o_height    (height),
        .o_height_m1 (height_m1),
        .o_alpha     (alpha_present),
        .o_rle       (rle),
        .o_bottom_up (bottom_up)
    );

    // byte intake and span sequencing
    tgadec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // packet and pixel state, row and column counters, output register
    tgadec_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_byte      (s_axis_tdata[BYTE_W-1:0]),
        .i_width     (width),
        .i_height    (height),
        .i_height_m1 (height_m1),
        .i_alpha     (alpha_present),
        .i_rle       (rle),
        .i_bottom_up (bottom_up),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
